### design/radar_target_frame_parser_unit_defines.svh
// Assertion macros for the radar target frame parser.
// Clock is clk, reset is rst_n (active low) in every user of these macros.
`ifndef RADAR_TARGET_FRAME_PARSER_UNIT_DEFINES_SVH
`define RADAR_TARGET_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RTFP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtfp assertion failed");
// Next-cycle implication.
`define RTFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtfp assertion failed");
`else
`define RTFP_ASSERT_IMPL(label, ante, cons)
`define RTFP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/rtfp_pkg.sv
package rtfp_pkg;

    // Frame layout
    localparam int unsigned DATA_DEPTH = 24;
    localparam int unsigned ADDR_W     = $clog2(DATA_DEPTH);

    localparam logic [4:0] DATA_BYTES = 5'd24;   // count value of first tail byte
    localparam logic [4:0] TAIL_LAST  = 5'd25;   // count value of second tail byte

    // Header and tail bytes
    localparam logic [7:0] HDR_B0  = 8'hAA;
    localparam logic [7:0] HDR_B1  = 8'hFF;
    localparam logic [7:0] HDR_B2  = 8'h03;
    localparam logic [7:0] HDR_B3  = 8'h00;
    localparam logic [7:0] TAIL_B0 = 8'h55;
    localparam logic [7:0] TAIL_B1 = 8'hCC;

    localparam logic [1:0] LAST_TARGET = 2'd2;
    localparam logic [1:0] LAST_WORD   = 2'd2;   // x, y, speed converted
    localparam logic [2:0] REC_LAST_BYTE = 3'd7;

    typedef enum logic [2:0] {
        HUNT_AA,
        HUNT_FF,
        HUNT_03,
        HUNT_00,
        HUNT_CAPTURE
    } rtfp_hunt_t;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_ADDR,
        DEC_DATA,
        DEC_CONV,
        DEC_EMIT
    } rtfp_dec_t;

    // Frame store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } rtfp_wr_t;

    // Sign-magnitude to two's complement: bit 15 set means positive.
    function automatic logic signed [15:0] sm_decode(input logic [15:0] w);
        logic [15:0] mag;
        mag = {1'b0, w[14:0]};
        sm_decode = w[15] ? mag : (16'd0 - mag);
    endfunction

endpackage

### design/rtfp_ram.sv
module rtfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/rtfp_hunt.sv
module rtfp_hunt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  logic [7:0]       rx_byte,
    output rtfp_pkg::rtfp_wr_t wr,
    output logic             start
);

    rtfp_pkg::rtfp_hunt_t state_reg, state_next;
    logic [4:0] count_reg, count_next;
    logic       tail_ok_reg, tail_ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rtfp_pkg::HUNT_AA;
            count_reg   <= 5'd0;
            tail_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tail_ok_reg <= tail_ok_next;
        end
    end

    // Next state, capture count and tail flag
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        tail_ok_next = tail_ok_reg;
        if (acc)
        begin
            unique case (state_reg)
                rtfp_pkg::HUNT_FF:
                    state_next = (rx_byte == rtfp_pkg::HDR_B1) ? rtfp_pkg::HUNT_03
                                                               : rtfp_pkg::HUNT_AA;
                rtfp_pkg::HUNT_03:
                    state_next = (rx_byte == rtfp_pkg::HDR_B2) ? rtfp_pkg::HUNT_00
                                                               : rtfp_pkg::HUNT_AA;
                rtfp_pkg::HUNT_00:
                begin
                    if (rx_byte == rtfp_pkg::HDR_B3)
                    begin
                        state_next   = rtfp_pkg::HUNT_CAPTURE;
                        count_next   = 5'd0;
                        tail_ok_next = 1'b0;
                    end
                    else
                    begin
                        state_next = rtfp_pkg::HUNT_AA;
                    end
                end
                rtfp_pkg::HUNT_CAPTURE:
                begin
                    if (count_reg < rtfp_pkg::DATA_BYTES)
                    begin
                        count_next = count_reg + 5'd1;
                    end
                    else if (count_reg == rtfp_pkg::DATA_BYTES)
                    begin
                        tail_ok_next = (rx_byte == rtfp_pkg::TAIL_B0);
                        count_next   = count_reg + 5'd1;
                    end
                    else
                    begin
                        state_next   = rtfp_pkg::HUNT_AA;
                        count_next   = 5'd0;
                        tail_ok_next = 1'b0;
                    end
                end
                default:
                    state_next = (rx_byte == rtfp_pkg::HDR_B0) ? rtfp_pkg::HUNT_FF
                                                               : rtfp_pkg::HUNT_AA;
            endcase
        end
    end

    // Store writes and frame-good pulse
    always_comb
    begin
        wr.en   = acc && (state_reg == rtfp_pkg::HUNT_CAPTURE)
                      && (count_reg < rtfp_pkg::DATA_BYTES);
        wr.addr = count_reg[rtfp_pkg::ADDR_W-1:0];
        wr.data = rx_byte;
        start   = acc && (state_reg == rtfp_pkg::HUNT_CAPTURE)
                      && (count_reg == rtfp_pkg::TAIL_LAST)
                      && tail_ok_reg && (rx_byte == rtfp_pkg::TAIL_B1);
    end

endmodule

### design/rtfp_decode.sv
module rtfp_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [7:0]                  rd_data,
    output logic [rtfp_pkg::ADDR_W-1:0] rd_addr,
    output logic                        busy,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [1:0]                  target_index,
    output logic                        detected,
    output logic signed [15:0]          x_pos,
    output logic signed [15:0]          y_pos,
    output logic signed [15:0]          speed,
    output logic                        last
);

    rtfp_pkg::rtfp_dec_t state_reg, state_next;

    logic [4:0]  byte_cnt_reg, byte_cnt_next;
    logic [1:0]  rec_idx_reg, rec_idx_next;
    logic [1:0]  conv_idx_reg, conv_idx_next;
    logic [63:0] rec_reg, rec_next;
    logic signed [15:0] wx_reg, wx_next;
    logic signed [15:0] wy_reg, wy_next;
    logic signed [15:0] ws_reg, ws_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_idx_reg, out_idx_next;
    logic               out_det_reg, out_det_next;
    logic signed [15:0] out_x_reg, out_x_next;
    logic signed [15:0] out_y_reg, out_y_next;
    logic signed [15:0] out_s_reg, out_s_next;
    logic               out_last_reg, out_last_next;

    logic [15:0]        conv_word;
    logic signed [15:0] conv_val;
    logic               rec_det;
    logic               emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtfp_pkg::DEC_IDLE;
            byte_cnt_reg  <= 5'd0;
            rec_idx_reg   <= 2'd0;
            conv_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            rec_idx_reg   <= rec_idx_next;
            conv_idx_reg  <= conv_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg      <= rec_next;
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        ws_reg       <= ws_next;
        out_idx_reg  <= out_idx_next;
        out_det_reg  <= out_det_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_s_reg    <= out_s_next;
        out_last_reg <= out_last_next;
    end

    assign emit    = (state_reg == rtfp_pkg::DEC_EMIT) && (!out_valid_reg || !res_stall);
    assign rec_det = |rec_reg;

    // Shared sign-magnitude converter, one word per cycle
    always_comb
    begin
        case (conv_idx_reg)
            2'd0:    conv_word = rec_reg[15:0];
            2'd1:    conv_word = rec_reg[31:16];
            default: conv_word = rec_reg[47:32];
        endcase
        conv_val = rtfp_pkg::sm_decode(conv_word);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtfp_pkg::DEC_IDLE:
                if (start)
                begin
                    state_next = rtfp_pkg::DEC_ADDR;
                end
            rtfp_pkg::DEC_ADDR:
                state_next = rtfp_pkg::DEC_DATA;
            rtfp_pkg::DEC_DATA:
                state_next = (byte_cnt_reg[2:0] == rtfp_pkg::REC_LAST_BYTE)
                           ? rtfp_pkg::DEC_CONV : rtfp_pkg::DEC_ADDR;
            rtfp_pkg::DEC_CONV:
                if (conv_idx_reg == rtfp_pkg::LAST_WORD)
                begin
                    state_next = rtfp_pkg::DEC_EMIT;
                end
            rtfp_pkg::DEC_EMIT:
                if (emit)
                begin
                    state_next = (rec_idx_reg == rtfp_pkg::LAST_TARGET)
                               ? rtfp_pkg::DEC_IDLE : rtfp_pkg::DEC_ADDR;
                end
            default:
                state_next = rtfp_pkg::DEC_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        byte_cnt_next  = byte_cnt_reg;
        rec_idx_next   = rec_idx_reg;
        conv_idx_next  = conv_idx_reg;
        rec_next       = rec_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        ws_next        = ws_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_idx_next   = out_idx_reg;
        out_det_next   = out_det_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_s_next     = out_s_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            rtfp_pkg::DEC_IDLE:
            begin
                byte_cnt_next = 5'd0;
                rec_idx_next  = 2'd0;
            end
            rtfp_pkg::DEC_DATA:
            begin
                rec_next      = {rd_data, rec_reg[63:8]};
                byte_cnt_next = byte_cnt_reg + 5'd1;
                conv_idx_next = 2'd0;
            end
            rtfp_pkg::DEC_CONV:
            begin
                case (conv_idx_reg)
                    2'd0:    wx_next = conv_val;
                    2'd1:    wy_next = conv_val;
                    default: ws_next = conv_val;
                endcase
                conv_idx_next = conv_idx_reg + 2'd1;
            end
            rtfp_pkg::DEC_EMIT:
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = rec_idx_reg;
                    out_det_next   = rec_det;
                    out_x_next     = rec_det ? wx_reg : 16'sd0;
                    out_y_next     = rec_det ? wy_reg : 16'sd0;
                    out_s_next     = rec_det ? ws_reg : 16'sd0;
                    out_last_next  = (rec_idx_reg == rtfp_pkg::LAST_TARGET);
                    rec_idx_next   = rec_idx_reg + 2'd1;
                end
            default:
            begin
            end
        endcase
    end

    assign rd_addr      = byte_cnt_reg[rtfp_pkg::ADDR_W-1:0];
    assign busy         = (state_reg != rtfp_pkg::DEC_IDLE);
    assign res_valid    = out_valid_reg;
    assign target_index = out_idx_reg;
    assign detected     = out_det_reg;
    assign x_pos        = out_x_reg;
    assign y_pos        = out_y_reg;
    assign speed        = out_s_reg;
    assign last         = out_last_reg;

endmodule

### design/radar_target_frame_parser_unit.sv
// Radar target frame parser. Bytes from the radar serial link come in one beat at a
// time on rx_byte (rx_valid / rx_stall). The unit hunts for the header AA FF 03 00;
// a wrong header byte sends the hunt back to waiting for AA without re-checking that
// byte. After the header, 24 data bytes go to a small frame store and two tail bytes
// are checked. On tail 55 CC the unit emits three result beats (target 0, 1, 2, last
// set on target 2) on res_valid / res_stall; a bad tail gives nothing. Each target
// record is four little-endian words x, y, speed, distance; a record of all zero
// words is reported as not detected with zero coordinates, otherwise x, y and speed
// are decoded from sign-magnitude (bit 15 set = positive). Rate: while hunting and
// capturing, one byte is taken every clock while rx_stall is low. The beat carrying
// the last tail byte of a good frame starts the decoder, and rx_stall stays high until
// the decode is done, including time the output spends stalled: per target, 8 store
// reads through the single registered read port, x, y and speed through the one
// shared sign-magnitude converter, and a load of the output register. The third
// result may still sit in the output register while the next bytes are taken.
`include "radar_target_frame_parser_unit_defines.svh"

module radar_target_frame_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         target_index,
    output logic               detected,
    output logic signed [15:0] x_pos,
    output logic signed [15:0] y_pos,
    output logic signed [15:0] speed,
    output logic               last
);

    logic                        rx_acc;     // byte beat taken this cycle
    logic                        start;      // good frame, kick the decoder
    logic                        busy;
    rtfp_pkg::rtfp_wr_t          wr;
    logic [rtfp_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;

    // Input is held off for the whole decode of a frame.
    assign rx_stall = busy;
    assign rx_acc   = rx_valid && !rx_stall;

    // Header hunt, capture count and tail check
    rtfp_hunt u_hunt (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (rx_acc),
        .rx_byte (rx_byte),
        .wr      (wr),
        .start   (start)
    );

    // 24-byte frame store; written during capture, read by the decoder
    rtfp_ram #(
        .WIDTH (8),
        .DEPTH (rtfp_pkg::DATA_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Record sequencer with the shared converter and output register
    rtfp_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .busy         (busy),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .target_index (target_index),
        .detected     (detected),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .speed        (speed),
        .last         (last)
    );

    // last marks exactly the third target of a frame
    `RTFP_ASSERT_IMPL(a_last_index, res_valid, last == (target_index == rtfp_pkg::LAST_TARGET))
    // undetected targets carry zero coordinates
    `RTFP_ASSERT_IMPL(a_undet_zero, res_valid && !detected, (x_pos | y_pos | speed) == 16'sd0)
    // a good tail stops byte intake on the next cycle
    `RTFP_ASSERT_NEXT(a_start_stalls, start, rx_stall)

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtfp_pkg::*;

    // One decoded target as it should appear on the result channel
    typedef struct {
        logic [1:0]         idx;
        logic               det;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] spd;
        logic               lst;
    } target_t;

    localparam int MAX_WAIT   = 18;
    localparam int DRAIN_WAIT = 100;   // room for a whole decode plus output stalls
    localparam int N_ITEMS    = 330;   // byte beats over the whole run
    localparam int TAIL_ITEMS = 120;   // bytes of the two closing tests

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic [1:0]         target_index;
    logic               detected;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] speed;
    logic               last;

    // Frame parser state as predicted from the accepted byte stream
    rtfp_hunt_t         hunt_st = HUNT_AA;
    logic [4:0]         cap_count = '0;
    logic [7:0]         data_mem [24];
    logic               tail_head_ok = 1'b0;

    target_t            pending_targets [$];
    target_t            want_beat;
    logic [7:0]         frame_buf [24];

    int                 fails = 0;
    int                 sent_bytes = 0;
    bit                 rush = 1'b0;     // no drawn idle cycles on either side while set
    int                 hold_cnt = 0;    // long receiver hold-off, counted down below
    int                 res_wait = 0;    // stall cycles before the next result beat

    radar_target_frame_parser_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .target_index (target_index),
        .detected     (detected),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .speed        (speed),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Idle draw shared by sender and receiver: outside rush, at least half the beats go back to back,
    // the others draw a random wait.
    function automatic int draw_wait();
        if (rush || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Sign-magnitude word to two's complement; bit 15 set means positive.
    function automatic logic signed [15:0] sm_to_int(input logic [15:0] w);
        logic signed [15:0] mag;
        mag = signed'({1'b0, w[14:0]});
        if (w[15])
            return mag;
        return -mag;
    endfunction

    // Advance the predicted parser by one accepted byte; a good tail queues
    // the three targets of the frame.
    task automatic parse_byte(input logic [7:0] b);
        int          r;
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] ws;
        logic [15:0] wd;
        target_t     t;
        case (hunt_st)
            HUNT_FF: hunt_st = (b == HDR_B1) ? HUNT_03 : HUNT_AA;
            HUNT_03: hunt_st = (b == HDR_B2) ? HUNT_00 : HUNT_AA;
            HUNT_00:
            begin
                if (b == HDR_B3)
                begin
                    cap_count = '0;
                    tail_head_ok = 1'b0;
                    hunt_st = HUNT_CAPTURE;
                end
                else
                begin
                    hunt_st = HUNT_AA;
                end
            end
            HUNT_CAPTURE:
            begin
                if (cap_count < DATA_BYTES)
                begin
                    data_mem[cap_count] = b;
                    cap_count++;
                end
                else if (cap_count == DATA_BYTES)
                begin
                    tail_head_ok = (b == TAIL_B0);
                    cap_count++;
                end
                else
                begin
                    if (tail_head_ok && b == TAIL_B1)
                    begin
                        for (r = 0; r < 3; r++)
                        begin
                            wx = {data_mem[r*8+1], data_mem[r*8]};
                            wy = {data_mem[r*8+3], data_mem[r*8+2]};
                            ws = {data_mem[r*8+5], data_mem[r*8+4]};
                            wd = {data_mem[r*8+7], data_mem[r*8+6]};
                            t.idx = r[1:0];
                            t.det = |{wx, wy, ws, wd};
                            t.x   = t.det ? sm_to_int(wx) : 16'sd0;
                            t.y   = t.det ? sm_to_int(wy) : 16'sd0;
                            t.spd = t.det ? sm_to_int(ws) : 16'sd0;
                            t.lst = (r[1:0] == LAST_TARGET);
                            pending_targets.push_back(t);
                        end
                    end
                    hunt_st = HUNT_AA;
                    cap_count = '0;
                    tail_head_ok = 1'b0;
                end
            end
            default: hunt_st = (b == HDR_B0) ? HUNT_FF : HUNT_AA;
        endcase
    endtask

    // Offer one byte after a random idle stretch and hold it until accepted.
    // Called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        parse_byte(b);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] t0, input logic [7:0] t1);
        int i;
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B2);
        send_byte(HDR_B3);
        for (i = 0; i < 24; i++)
            send_byte(frame_buf[i]);
        send_byte(t0);
        send_byte(t1);
    endtask

    task automatic put_word(input int r, input int w, input logic [15:0] v);
        frame_buf[r*8 + w*2]     = v[7:0];
        frame_buf[r*8 + w*2 + 1] = v[15:8];
    endtask

    // Random payload: each record is all zero, distance only, built from
    // extreme words, or fully random.
    task automatic make_payload();
        int          r;
        int          w;
        int          kind;
        logic [15:0] v;
        for (r = 0; r < 3; r++)
        begin
            kind = $urandom_range(0, 5);
            for (w = 0; w < 4; w++)
            begin
                case (kind)
                    0: v = 16'h0000;
                    1: v = (w == 3) ? 16'($urandom_range(1, 65535)) : 16'h0000;
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0: v = 16'h0000;
                            1: v = 16'h8000;
                            2: v = 16'h7FFF;
                            default: v = 16'hFFFF;
                        endcase
                    end
                    default: v = 16'($urandom);
                endcase
                put_word(r, w, v);
            end
        end
    endtask

    task automatic wait_drain();
        while (pending_targets.size() != 0)
            @(negedge clk);
    endtask

    // Not detected, extreme words, positive and negative zero.
    task automatic test_target_decode();
        put_word(0, 0, 16'h0000);
        put_word(0, 1, 16'h0000);
        put_word(0, 2, 16'h0000);
        put_word(0, 3, 16'h0000);
        put_word(1, 0, 16'h8000);
        put_word(1, 1, 16'h7FFF);
        put_word(1, 2, 16'hFFFF);
        put_word(1, 3, 16'h0000);
        put_word(2, 0, 16'h0000);
        put_word(2, 1, 16'h0001);
        put_word(2, 2, 16'h8001);
        put_word(2, 3, 16'hFFFF);
        send_frame(TAIL_B0, TAIL_B1);
    endtask

    // The second header byte is broken twice, the fourth once; a repeated AA must not resync.
    task automatic test_header_hunt();
        send_byte(HDR_B0);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B2);
        send_byte(HDR_B3);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B2);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(HDR_B3);
        send_byte(HDR_B0);
        send_byte(HDR_B2);
        make_payload();
        send_frame(TAIL_B0, TAIL_B1);
    endtask

    // Wrong second tail byte, wrong first tail byte, swapped tail; then a good frame.
    task automatic test_bad_tail();
        make_payload();
        send_frame(TAIL_B0, 8'hCD);
        make_payload();
        send_frame(8'h54, TAIL_B1);
        make_payload();
        send_frame(TAIL_B1, TAIL_B0);
        make_payload();
        send_frame(TAIL_B0, TAIL_B1);
    endtask

    // Mostly good frames with random content; some noise, broken headers
    // and bad tails. Stretches without idling come and go. Runs until the
    // byte budget left for the closing tests is reached.
    task automatic test_random_traffic();
        int n;
        int i;
        while (sent_bytes < N_ITEMS - TAIL_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                rush = ~rush;
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_byte(8'($urandom));
                end
                1:
                begin
                    n = $urandom_range(1, 3);
                    send_byte(HDR_B0);
                    if (n > 1)
                        send_byte(HDR_B1);
                    if (n > 2)
                        send_byte(HDR_B2);
                    send_byte(8'($urandom));
                end
                2:
                begin
                    make_payload();
                    send_frame($urandom_range(0, 1) ? TAIL_B0 : 8'($urandom),
                               8'($urandom));
                end
                default:
                begin
                    make_payload();
                    send_frame(TAIL_B0, TAIL_B1);
                end
            endcase
        end
        rush = 1'b0;
    endtask

    // Receiver holds off long enough for the parser to back up onto rx_stall.
    task automatic test_backpressure();
        int i;
        hold_cnt = 300;
        rush = 1'b1;
        for (i = 0; i < 2; i++)
        begin
            make_payload();
            send_frame(TAIL_B0, TAIL_B1);
        end
        rush = 1'b0;
        wait_drain();
    endtask

    // Sender pauses until every target is out after each frame.
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 2; i++)
        begin
            make_payload();
            send_frame(TAIL_B0, TAIL_B1);
            wait_drain();
        end
    endtask

    // Receiver stall: the long hold first, then the per-beat draw.
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            res_stall <= 1'b1;
            hold_cnt--;
        end
        else if (res_wait > 0)
        begin
            res_stall <= 1'b1;
            res_wait--;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fails++;
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    // Result checker: every accepted beat against the oldest predicted target.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_targets.size() == 0)
            begin
                fails++;
                $error("result beat with nothing expected: target_index %0d", target_index);
            end
            else
            begin
                want_beat = pending_targets.pop_front();
                check_field("target_index", 16'(want_beat.idx), 16'(target_index));
                check_field("detected", 16'(want_beat.det), 16'(detected));
                check_field("x_pos", want_beat.x, x_pos);
                check_field("y_pos", want_beat.y, y_pos);
                check_field("speed", want_beat.spd, speed);
                check_field("last", 16'(want_beat.lst), 16'(last));
            end
            res_wait = draw_wait();
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_target_decode();
        test_header_hunt();
        test_bad_tail();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();

        rx_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (pending_targets.size() == 0 && fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
